/* design/ils_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared sizes, request and status codes, and control types.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 7;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [FUNC_W-1:0] FN_READ      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DELETE    = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_READ = 2'd1,
        K_INS  = 2'd2,
        K_DEL  = 2'd3
    } t_kind;

    typedef struct packed {
        logic accept;
        logic shift;
        logic commit;
        logic capture;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  shift_done;
        logic  out_free;
    } t_stat;

endpackage

/* design/indexed_list_store_unit.sv */
// ----------------------------------------------------------------------------
// Indexed list store unit
// A read passes through decode, read wait and response; a rejected word goes
// from decode to response; an insert or delete shifts m entries (up to
// CAPACITY - 1), one per cycle through the single write port of the entry
// memory, then commits and responds.
// One word is handled at a time; the next word can be taken in the cycle after
// the result is loaded, and a result is loaded only once the previous one is taken.
// Reset clears the count and all control state; entry contents are kept.
// ----------------------------------------------------------------------------
module indexed_list_store_unit
    import ils_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [STAT_W-1:0]        o_status,
    output logic [ECNT_W-1:0]        o_entry_count
);

    t_cmd  cmd;
    t_stat stat;

    ils_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    ils_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_entry_count(o_entry_count)
    );

endmodule

/* design/ils_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ils_ctrl.sv */
// ----------------------------------------------------------------------------
// Indexed list store controller
// Sequences the accept, decode, shift, commit, capture and response steps of one request.
// ----------------------------------------------------------------------------
module ils_ctrl
    import ils_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.kind)
                    K_READ:       n_state = S_RDWAIT;
                    K_INS, K_DEL: n_state = S_SHIFT;
                    default:      n_state = S_RESP;
                endcase
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_RDWAIT: begin
                o_cmd.capture = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.shift && o_cmd.commit))
        else $error("shift and commit issued together");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_DECODE))
        else $error("accepted word did not enter decode");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_stat.shift_done)
        else $error("commit while a shift write is still pending");

endmodule

/* design/ils_dp.sv */
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Request decode, entry memory with shift pipeline, count and result register.
// ----------------------------------------------------------------------------
module ils_dp
    import ils_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [POS_W-1:0]   i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [STAT_W-1:0]  o_status,
    output logic [ECNT_W-1:0]  o_entry_count
);

    logic [CNT_W-1:0]  r_count;
    t_kind             r_kind;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_res;
    logic [IDX_W-1:0]  r_ins_pos;
    logic [IDX_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_left;
    logic              r_wr_pend;
    logic [IDX_W-1:0]  r_wr_addr;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [STAT_W-1:0] r_out_status;
    logic [ECNT_W-1:0] r_out_count;

    t_kind             n_kind;
    logic [STAT_W-1:0] n_status;
    logic [CMP_W-1:0]  n_ins_pos;
    logic [CMP_W-1:0]  n_ptr;
    logic [CMP_W-1:0]  n_left;

    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;
    logic              full;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    assign pos_c = CMP_W'(i_position);
    assign cnt_c = CMP_W'(r_count);
    assign full  = (cnt_c >= CMP_W'(CAPACITY));

    always_comb begin
        n_kind    = K_NONE;
        n_status  = ST_RANGE;
        n_ins_pos = '0;
        unique case (i_func)
            FN_READ: begin
                if (pos_c < cnt_c) begin
                    n_kind   = K_READ;
                    n_status = ST_DONE;
                end
            end
            FN_INS_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_kind   = K_INS;
                    n_status = ST_DONE;
                end
            end
            FN_INS_END: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_kind    = K_INS;
                    n_status  = ST_DONE;
                    n_ins_pos = cnt_c;
                end
            end
            FN_INS_AT: begin
                priority if (pos_c > cnt_c) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_kind    = K_INS;
                    n_status  = ST_DONE;
                    n_ins_pos = pos_c;
                end
            end
            FN_DELETE: begin
                if (pos_c < cnt_c) begin
                    n_kind   = K_DEL;
                    n_status = ST_DONE;
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        n_ptr  = pos_c;
        n_left = '0;
        unique case (n_kind)
            K_INS: begin
                n_ptr  = cnt_c - CMP_W'(1);
                n_left = cnt_c - n_ins_pos;
            end
            K_DEL: begin
                n_ptr  = pos_c + CMP_W'(1);
                n_left = cnt_c - pos_c - CMP_W'(1);
            end
            default: begin
                n_left = '0;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;
        if (i_cmd.commit && (r_kind == K_INS)) begin
            ram_we    = 1'b1;
            ram_waddr = r_ins_pos;
            ram_wdata = r_value;
        end else if (i_cmd.shift && r_wr_pend) begin
            ram_we = 1'b1;
        end
    end

    ils_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_ptr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_kind      <= K_NONE;
            r_left      <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_kind    <= n_kind;
                r_left    <= CNT_W'(n_left);
                r_wr_pend <= 1'b0;
            end else if (i_cmd.shift) begin
                if (r_left != '0) begin
                    r_wr_pend <= 1'b1;
                    r_left    <= r_left - CNT_W'(1);
                end else begin
                    r_wr_pend <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                if (r_kind == K_INS) begin
                    r_count <= r_count + CNT_W'(1);
                end else if (r_kind == K_DEL) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status  <= n_status;
            r_value   <= i_value;
            r_res     <= '0;
            r_ins_pos <= IDX_W'(n_ins_pos);
            r_ptr     <= IDX_W'(n_ptr);
        end else if (i_cmd.shift && (r_left != '0)) begin
            if (r_kind == K_INS) begin
                r_wr_addr <= r_ptr + IDX_W'(1);
                r_ptr     <= r_ptr - IDX_W'(1);
            end else begin
                r_wr_addr <= r_ptr - IDX_W'(1);
                r_ptr     <= r_ptr + IDX_W'(1);
            end
        end
        if (i_cmd.capture) begin
            r_res <= ram_rdata;
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_res;
            r_out_status <= r_status;
            r_out_count  <= ECNT_W'(r_count);
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.shift_done = (r_left == '0) && !r_wr_pend;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("entry count above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_kind == K_INS)) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not raise the count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_kind == K_DEL)) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("delete did not lower the count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && !i_out_ready))
        else $error("result register overwritten before it was taken");

endmodule
